[rtl/core/lnp_pkg.sv]
// Package for the last-note-priority tone generator.
// Holds sizes, stack cell types and the half-period table lookup.
// No dependencies.
`timescale 1ns / 1ps

package lnp_pkg;

    // Sizes of the keyboard, the octave range and the period counter.
    localparam int NUM_KEYS     = 13;
    localparam int NUM_OCTAVES  = 5;
    localparam int PERIOD_WIDTH = 16;

    // Field widths of key and octave indexes.
    localparam int KEY_W = 4;
    localparam int OCT_W = 3;

    // Octave selected after reset.
    localparam int RESET_OCTAVE = 2 % NUM_OCTAVES;

    // Half-period table dimensions.
    localparam int ROM_OCTAVES = 5;
    localparam int ROM_KEYS    = 13;

    localparam logic [15:0] HALF_ROM [ROM_OCTAVES][ROM_KEYS] = '{
        '{16'd15288, 16'd14430, 16'd13620, 16'd12857, 16'd12134, 16'd11453, 16'd10811,
          16'd10204, 16'd9631, 16'd9091, 16'd8581, 16'd8099, 16'd7645},
        '{16'd7645, 16'd7215, 16'd6811, 16'd6428, 16'd6068, 16'd5727, 16'd5405,
          16'd5102, 16'd4816, 16'd4545, 16'd4290, 16'd4049, 16'd3822},
        '{16'd3822, 16'd3608, 16'd3405, 16'd3214, 16'd3034, 16'd2863, 16'd2703,
          16'd2551, 16'd2408, 16'd2272, 16'd2145, 16'd2025, 16'd1911},
        '{16'd1911, 16'd1804, 16'd1703, 16'd1607, 16'd1517, 16'd1432, 16'd1351,
          16'd1275, 16'd1204, 16'd1136, 16'd1073, 16'd1012, 16'd955},
        '{16'd955, 16'd902, 16'd851, 16'd803, 16'd758, 16'd716, 16'd676,
          16'd638, 16'd602, 16'd568, 16'd536, 16'd506, 16'd477}
    };

    // One entry of the key stack.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } entry_t;

    // Shift commands common to every stack cell.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

    // Table lookup; indexes beyond the table saturate at the last row and column.
    function automatic logic [PERIOD_WIDTH-1:0] half_lookup(
        input logic [OCT_W-1:0] oct,
        input logic [KEY_W-1:0] key
    );
        int          o;
        int          k;
        logic [31:0] wide;
        o = (int'(oct) < ROM_OCTAVES) ? int'(oct) : ROM_OCTAVES - 1;
        k = (int'(key) < ROM_KEYS) ? int'(key) : ROM_KEYS - 1;
        wide = 32'(HALF_ROM[o][k]);
        return wide[PERIOD_WIDTH-1:0];
    endfunction

endpackage

[rtl/core/lnp_cell.sv]
// One cell of the key stack chain: holds a single stack entry.
// On push it takes the entry of the cell above, on pop the entry of the cell below.
// Depends on lnp_pkg.
`timescale 1ns / 1ps

module lnp_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  lnp_pkg::cell_ctrl_t ctrl,
    input  lnp_pkg::entry_t     from_above,
    input  lnp_pkg::entry_t     from_below,
    output lnp_pkg::entry_t     entry
);
    import lnp_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;

    // Select the neighbor that shifts in.
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (ctrl.push)
        begin
            valid_next = from_above.valid;
            key_next   = from_above.key;
        end
        else if (ctrl.pop)
        begin
            valid_next = from_below.valid;
            key_next   = from_below.key;
        end
    end

    // The valid bit is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // The key index is payload.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;

endmodule

[rtl/core/lnp_tone.sv]
// Square-wave tone unit: tick counter and output level.
// Advances once per tick and reports the wave level after that tick.
// Depends on lnp_pkg.
`timescale 1ns / 1ps

module lnp_tone (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick,
    input  logic                             active,
    input  logic [lnp_pkg::PERIOD_WIDTH-1:0] half,
    output logic                             wave_next
);
    import lnp_pkg::*;

    logic [PERIOD_WIDTH-1:0] count_reg;
    logic [PERIOD_WIDTH-1:0] count_next;
    logic [PERIOD_WIDTH-1:0] count_inc;
    logic                    wave_reg;

    // Count up while a key sounds and clear on a silent tick; toggle and restart on reaching the half period.
    always_comb
    begin
        count_inc  = count_reg + PERIOD_WIDTH'(1);
        count_next = count_reg;
        wave_next  = wave_reg;
        if (tick)
        begin
            if (active)
            begin
                if (count_inc >= half)
                begin
                    wave_next  = ~wave_reg;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            else
            begin
                count_next = '0;
            end
        end
    end

    // Counter and level registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wave_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            wave_reg  <= wave_next;
        end
    end

endmodule

[rtl/core/last_note_priority_tone_generator_top.sv]
// Top level of the last-note-priority tone generator.
// Instantiates the stack cell chain (lnp_cell) and the tone unit (lnp_tone); uses lnp_pkg.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+-----------------------------------------------
//   in      | in_valid/in_ready  | key_levels, octave_down, octave_up
//   out     | out_valid/out_ready| wave_level, tone_active, current_key,
//           |                    | current_octave, half_period
//
// A tick scans NUM_KEYS keys for pushes (one per cycle), pops one released key per cycle,
// then finds a held top (S_POP) and updates the tone (S_TONE): the result is registered
// as the tone unit advances, and the next tick is accepted only once the sequencer is back
// in S_IDLE, so a new tick is never taken before the last one is through.
// A stalled output holds its transfer; the following tick waits in its tone cycle.
// Reset empties the stack, clears the counter and level, and selects octave two.
`timescale 1ns / 1ps

module last_note_priority_tone_generator_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [lnp_pkg::NUM_KEYS-1:0]     key_levels,
    input  logic                             octave_down,
    input  logic                             octave_up,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             wave_level,
    output logic                             tone_active,
    output logic [lnp_pkg::KEY_W-1:0]        current_key,
    output logic [lnp_pkg::OCT_W-1:0]        current_octave,
    output logic [lnp_pkg::PERIOD_WIDTH-1:0] half_period
);
    import lnp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PUSH = 4'b0010,
        S_POP  = 4'b0100,
        S_TONE = 4'b1000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [NUM_KEYS-1:0]     levels_reg;
    logic [NUM_KEYS-1:0]     levels_next;
    logic [NUM_KEYS-1:0]     flags_reg;
    logic [NUM_KEYS-1:0]     flags_next;
    logic [OCT_W-1:0]        oct_reg;
    logic [OCT_W-1:0]        oct_next;
    logic [OCT_W-1:0]        oct_down;
    logic [OCT_W:0]          oct_up_sum;
    logic [KEY_W-1:0]        scan_reg;
    logic [KEY_W-1:0]        scan_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    wave_out_reg;
    logic                    active_out_reg;
    logic [KEY_W-1:0]        key_out_reg;
    logic [OCT_W-1:0]        oct_out_reg;
    logic [PERIOD_WIDTH-1:0] half_out_reg;

    logic                    in_fire;
    logic                    out_free;
    logic                    push_en;
    logic                    pop_en;
    logic                    tone_tick;
    logic                    stack_active;
    logic [PERIOD_WIDTH-1:0] half_sel;
    logic                    wave_next;
    cell_ctrl_t              cell_ctrl;
    entry_t                  cells [NUM_KEYS];
    entry_t                  push_entry;
    logic [NUM_KEYS-1:0]     valid_vec;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // Octave step for an accepted tick: down first, then up, each wrapping.
    always_comb
    begin
        oct_down   = (oct_reg == '0) ? OCT_W'(NUM_OCTAVES - 1) : oct_reg - OCT_W'(1);
        if (!octave_down)
        begin
            oct_down = oct_reg;
        end
        oct_up_sum = {1'b0, oct_down} + (OCT_W + 1)'(1);
    end

    // Top of the stack, and the push and pop decisions.
    assign stack_active = cells[0].valid;
    assign push_en    = (state_reg == S_PUSH) && levels_reg[scan_reg] && !flags_reg[scan_reg]
                        && !cells[NUM_KEYS-1].valid;
    assign pop_en     = (state_reg == S_POP) && cells[0].valid && !levels_reg[cells[0].key];
    assign tone_tick  = (state_reg == S_TONE) && out_free;
    assign cell_ctrl.push = push_en;
    assign cell_ctrl.pop  = pop_en;
    assign push_entry.valid = 1'b1;
    assign push_entry.key   = scan_reg;

    // Stack chain: cell 0 is the top.
    genvar i;
    generate
        for (i = 0; i < NUM_KEYS; i++)
        begin : g_cell
            entry_t above;
            entry_t below;
            if (i == 0)
            begin : g_first
                assign above = push_entry;
            end
            else
            begin : g_mid_above
                assign above = cells[i-1];
            end
            if (i == NUM_KEYS - 1)
            begin : g_last
                assign below = '0;
            end
            else
            begin : g_mid_below
                assign below = cells[i+1];
            end
            lnp_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .from_above (above),
                .from_below (below),
                .entry      (cells[i])
            );
            assign valid_vec[i] = cells[i].valid;
        end
    endgenerate

    // Half period for the key on top in the current octave.
    assign half_sel = stack_active ? half_lookup(oct_reg, cells[0].key) : '0;

    lnp_tone u_tone (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tone_tick),
        .active    (stack_active),
        .half      (half_sel),
        .wave_next (wave_next)
    );

    // Sequencer: accept, scan for pushes, pop released keys, update the tone.
    always_comb
    begin
        state_next     = state_reg;
        levels_next    = levels_reg;
        flags_next     = flags_reg;
        oct_next       = oct_reg;
        scan_next      = scan_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    levels_next = key_levels;
                    if (octave_up)
                    begin
                        oct_next = (oct_up_sum >= (OCT_W + 1)'(NUM_OCTAVES)) ? '0
                                   : oct_up_sum[OCT_W-1:0];
                    end
                    else
                    begin
                        oct_next = oct_down;
                    end
                    scan_next  = '0;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (push_en)
                begin
                    flags_next[scan_reg] = 1'b1;
                end
                if (scan_reg == KEY_W'(NUM_KEYS - 1))
                begin
                    state_next = S_POP;
                end
                else
                begin
                    scan_next = scan_reg + KEY_W'(1);
                end
            end
            S_POP:
            begin
                if (pop_en)
                begin
                    flags_next[cells[0].key] = 1'b0;
                end
                else
                begin
                    state_next = S_TONE;
                end
            end
            S_TONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            flags_reg     <= '0;
            oct_reg       <= OCT_W'(RESET_OCTAVE);
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flags_reg     <= flags_next;
            oct_reg       <= oct_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: latched key levels and the output transfer.
    always_ff @(posedge clk)
    begin
        levels_reg <= levels_next;
        if (tone_tick)
        begin
            wave_out_reg   <= wave_next;
            active_out_reg <= stack_active;
            key_out_reg    <= stack_active ? cells[0].key : '0;
            oct_out_reg    <= oct_reg;
            half_out_reg   <= half_sel;
        end
    end

    assign out_valid      = out_valid_reg;
    assign wave_level     = wave_out_reg;
    assign tone_active    = active_out_reg;
    assign current_key    = key_out_reg;
    assign current_octave = oct_out_reg;
    assign half_period    = half_out_reg;

    // Every stacked key has its flag set, and no flag without a stacked key.
    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == $countones(flags_reg))
        else $error("stack depth and on-stack flags disagree");

    // An accepted tick always starts the push scan at key zero.
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_PUSH) && (scan_reg == '0))
        else $error("push scan did not start at key zero");

    // A silent result reports key zero and a zero half period.
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !tone_active) |-> (current_key == '0) && (half_period == '0))
        else $error("silent result carries a key or period");

    // A sounding result names a real key.
    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && tone_active) |-> (current_key <= KEY_W'(NUM_KEYS - 1)))
        else $error("sounding result names a key beyond the keyboard");

    // A tone update only fires when the output register can take it.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !tone_tick)
        else $error("pending result overwritten");

endmodule

[tb/last_note_priority_tone_generator_top_test.sv]
// Self-checking testbench for last_note_priority_tone_generator_top.
// Drives timer ticks through a directed table and then random key phrases, and checks every
// tone transfer against a local predictor. Depends on lnp_pkg and the top module only.
`timescale 1ns / 1ps

module last_note_priority_tone_generator_top_test;
    import lnp_pkg::*;

    // Run lengths and limits.
    localparam int RANDOM_ITEMS    = 950;
    localparam int PHASE_ITEMS     = 120;
    localparam int HOLD_OFF_AT     = 300;
    localparam int DRAIN_AT        = 520;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 2 * NUM_KEYS + 8;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int DIRECTED_ROWS   = 22;

    // Idle and stall percentages of the four traffic phases.
    localparam int SEND_IDLE_PCT [4] = '{0, 60, 0, 7};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 60, 7};

    // Half periods in ticks, by octave and key.
    localparam logic [15:0] TONE_HALF [5][13] = '{
        '{16'd15288, 16'd14430, 16'd13620, 16'd12857, 16'd12134, 16'd11453, 16'd10811,
          16'd10204, 16'd9631, 16'd9091, 16'd8581, 16'd8099, 16'd7645},
        '{16'd7645, 16'd7215, 16'd6811, 16'd6428, 16'd6068, 16'd5727, 16'd5405,
          16'd5102, 16'd4816, 16'd4545, 16'd4290, 16'd4049, 16'd3822},
        '{16'd3822, 16'd3608, 16'd3405, 16'd3214, 16'd3034, 16'd2863, 16'd2703,
          16'd2551, 16'd2408, 16'd2272, 16'd2145, 16'd2025, 16'd1911},
        '{16'd1911, 16'd1804, 16'd1703, 16'd1607, 16'd1517, 16'd1432, 16'd1351,
          16'd1275, 16'd1204, 16'd1136, 16'd1073, 16'd1012, 16'd955},
        '{16'd955, 16'd902, 16'd851, 16'd803, 16'd758, 16'd716, 16'd676,
          16'd638, 16'd602, 16'd568, 16'd536, 16'd506, 16'd477}
    };

    // One tone transfer as seen on the output channel.
    typedef struct packed {
        logic                    wave;
        logic                    active;
        logic [KEY_W-1:0]        key;
        logic [OCT_W-1:0]        octave;
        logic [PERIOD_WIDTH-1:0] half;
    } tone_t;

    // One row of directed stimulus; typed rows carry their own expected tone.
    typedef struct packed {
        logic [NUM_KEYS-1:0] levels;
        logic                down;
        logic                up;
        logic                typed;
        tone_t               want;
    } tick_row_t;

    localparam tick_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Silent after reset, octave two.
        '{13'h0000, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 4'd0, 3'd2, 16'd0}},
        // Lowest key alone.
        '{13'h0001, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 4'd0, 3'd2, 16'd3822}},
        // Every key held: keys one to twelve pushed in order, highest on top.
        '{13'h1FFF, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 4'd12, 3'd2, 16'd1911}},
        // Keys below the top released; the top still sounds.
        '{13'h1000, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 4'd12, 3'd2, 16'd1911}},
        // Everything released: the whole stack pops.
        '{13'h0000, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 4'd0, 3'd2, 16'd0}},
        // Octave steps down and wraps from zero to four.
        '{13'h0000, 1'b1, 1'b0, 1'b1, '{1'b0, 1'b0, 4'd0, 3'd1, 16'd0}},
        '{13'h0000, 1'b1, 1'b0, 1'b1, '{1'b0, 1'b0, 4'd0, 3'd0, 16'd0}},
        '{13'h0000, 1'b1, 1'b0, 1'b1, '{1'b0, 1'b0, 4'd0, 3'd4, 16'd0}},
        // Step up wraps from four to zero.
        '{13'h0000, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, 4'd0, 3'd0, 16'd0}},
        // Both requests in one tick cancel.
        '{13'h0000, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 4'd0, 3'd0, 16'd0}},
        '{13'h0000, 1'b0, 1'b1, 1'b0, '0},
        '{13'h0000, 1'b0, 1'b1, 1'b0, '0},
        // A key released below the top stays stacked and is not pushed again.
        '{13'h0008, 1'b0, 1'b0, 1'b0, '0},
        '{13'h0028, 1'b0, 1'b0, 1'b0, '0},
        '{13'h0020, 1'b0, 1'b0, 1'b0, '0},
        '{13'h0028, 1'b0, 1'b0, 1'b0, '0},
        '{13'h0008, 1'b0, 1'b0, 1'b0, '0},
        // Octave changes while a key sounds.
        '{13'h1008, 1'b0, 1'b1, 1'b0, '0},
        '{13'h1008, 1'b1, 1'b0, 1'b0, '0},
        // Idle clears the counter and holds the level.
        '{13'h0000, 1'b0, 1'b0, 1'b0, '0},
        '{13'h1FFF, 1'b1, 1'b1, 1'b0, '0},
        '{13'h0000, 1'b0, 1'b0, 1'b0, '0}
    };

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [NUM_KEYS-1:0]     key_levels = '0;
    logic                    octave_down = 1'b0;
    logic                    octave_up = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    wave_level;
    logic                    tone_active;
    logic [KEY_W-1:0]        current_key;
    logic [OCT_W-1:0]        current_octave;
    logic [PERIOD_WIDTH-1:0] half_period;

    // Predictor state, at its reset values.
    logic [KEY_W-1:0]        note_stack [NUM_KEYS];
    int                      note_depth = 0;
    logic [NUM_KEYS-1:0]     note_flags = '0;
    logic [OCT_W-1:0]        octave_sel = OCT_W'(RESET_OCTAVE);
    logic [PERIOD_WIDTH-1:0] tick_count = '0;
    logic                    wave_now = 1'b0;

    tone_t tone_queue [$];
    int    mismatch_count = 0;
    int    cycle_count = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    hold_request = 1'b0;

    last_note_priority_tone_generator_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .key_levels     (key_levels),
        .octave_down    (octave_down),
        .octave_up      (octave_up),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .wave_level     (wave_level),
        .tone_active    (tone_active),
        .current_key    (current_key),
        .current_octave (current_octave),
        .half_period    (half_period)
    );

    // Clock.
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Advances the predictor by one tick and returns the tone it should produce.
    function automatic tone_t advance_tone(
        input logic [NUM_KEYS-1:0] levels,
        input logic                down,
        input logic                up
    );
        tone_t            res;
        logic [KEY_W-1:0] top;
        res = '0;

        // Newly held keys go on the stack in index order.
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (levels[k] && !note_flags[k] && note_depth < NUM_KEYS)
            begin
                note_flags[k] = 1'b1;
                note_stack[note_depth] = KEY_W'(k);
                note_depth++;
            end
        end

        // Down is applied before up, each with wraparound.
        if (down)
            octave_sel = (octave_sel == 0) ? OCT_W'(NUM_OCTAVES - 1) : octave_sel - 1'b1;
        if (up)
            octave_sel = (int'(octave_sel) + 1 >= NUM_OCTAVES) ? '0 : octave_sel + 1'b1;

        // Released keys come off the top until a held key surfaces.
        while (note_depth > 0 && !levels[note_stack[note_depth-1]])
        begin
            note_flags[note_stack[note_depth-1]] = 1'b0;
            note_depth--;
        end

        // The counter runs only while a key sounds and toggles the level on reaching the half period.
        if (note_depth > 0)
        begin
            top = note_stack[note_depth-1];
            res.active = 1'b1;
            res.key = top;
            res.half = TONE_HALF[octave_sel][top];
            tick_count = tick_count + 1'b1;
            if (tick_count >= res.half)
            begin
                wave_now = ~wave_now;
                tick_count = '0;
            end
        end
        else
            tick_count = '0;

        res.wave = wave_now;
        res.octave = octave_sel;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offers one tick with random idle gaps and records the expected tone on transfer.
    task automatic send_tick(
        input logic [NUM_KEYS-1:0] levels,
        input logic                down,
        input logic                up,
        input logic                typed,
        input tone_t               want
    );
        tone_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        key_levels = levels;
        octave_down = down;
        octave_up = up;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = advance_tone(levels, down, up);
        tone_queue.push_back(typed ? want : predicted);
    endtask

    // Random tick: picks the traffic phase, triggers the long stall and the drain.
    task automatic send_random(input logic [NUM_KEYS-1:0] levels, inout int sent);
        int phase;
        phase = (sent / PHASE_ITEMS) % 4;
        send_idle_pct = SEND_IDLE_PCT[phase];
        recv_stall_pct = RECV_STALL_PCT[phase];
        if (sent == HOLD_OFF_AT)
            hold_request = 1'b1;
        if (sent == DRAIN_AT)
        begin
            // The sender goes quiet until every expected transfer has arrived.
            @(negedge clk);
            in_valid = 1'b0;
            while (tone_queue.size() != 0)
                @(posedge clk);
        end
        send_tick(levels, $urandom_range(0, 99) < 5, $urandom_range(0, 99) < 5, 1'b0, '0);
        sent++;
    endtask

    // Stimulus: reset, directed table, then random phrases over a drone key.
    initial
    begin
        int                  sent;
        int                  phrase_len;
        int                  drone;
        int                  pick;
        logic [NUM_KEYS-1:0] chord;
        sent = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_tick(DIRECTED[r].levels, DIRECTED[r].down, DIRECTED[r].up,
                      DIRECTED[r].typed, DIRECTED[r].want);

        while (sent < RANDOM_ITEMS)
        begin
            // Most phrases are short; some run long enough for the counter to wrap the level.
            phrase_len = ($urandom_range(0, 3) == 0) ? $urandom_range(300, 650)
                                                     : $urandom_range(4, 60);
            drone = $urandom_range(0, NUM_KEYS - 1);
            chord = '0;
            chord[drone] = 1'b1;
            for (int n = 0; n < phrase_len && sent < RANDOM_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    chord[$urandom_range(0, NUM_KEYS - 1)] ^= 1'b1;
                    chord[drone] = 1'b1;
                end
                else if (pick < 45)
                    chord = NUM_KEYS'($urandom_range(0, 8191)) | (NUM_KEYS'(1) << drone);
                else if (pick < 48)
                    // Broken phrase: the drone may drop out.
                    chord = NUM_KEYS'($urandom_range(0, 8191));
                send_random(chord, sent);
            end
            repeat ($urandom_range(1, 2))
                send_random('0, sent);
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (tone_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("last_note_priority_tone_generator_top regression: pass");
        else
            $display("last_note_priority_tone_generator_top regression: fail");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else
                out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each tone transfer with the oldest expectation.
    always @(posedge clk)
    begin : check_tone
        tone_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (tone_queue.size() == 0)
                report_mismatch("unexpected transfer, half_period", half_period, 0);
            else
            begin
                want = tone_queue.pop_front();
                if (wave_level !== want.wave)
                    report_mismatch("wave_level", wave_level, want.wave);
                if (tone_active !== want.active)
                    report_mismatch("tone_active", tone_active, want.active);
                if (current_key !== want.key)
                    report_mismatch("current_key", current_key, want.key);
                if (current_octave !== want.octave)
                    report_mismatch("current_octave", current_octave, want.octave);
                if (half_period !== want.half)
                    report_mismatch("half_period", half_period, want.half);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("last_note_priority_tone_generator_top regression: fail");
            $finish;
        end
    end

endmodule

[last_note_priority_tone_generator_top.f]
rtl/core/lnp_pkg.sv
rtl/core/lnp_cell.sv
rtl/core/lnp_tone.sv
rtl/core/last_note_priority_tone_generator_top.sv
tb/last_note_priority_tone_generator_top_test.sv
